/* rtl/satq_pkg.sv */
// shared types, codes and helpers of the sorted alarm timer queue
package satq_pkg;

    localparam int NUM_ALARMS_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int TW             = 63;   // time width
    localparam int PW             = 32;   // period width
    localparam int HW             = 8;    // handler tag width
    localparam int IN_DATA_W      = 176;
    localparam int OUT_DATA_W     = 80;

    localparam logic [2:0] REQ_REL      = 3'd0;
    localparam logic [2:0] REQ_ABS      = 3'd1;
    localparam logic [2:0] REQ_PERIODIC = 3'd2;
    localparam logic [2:0] REQ_CANCEL   = 3'd3;
    localparam logic [2:0] REQ_FIRE     = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RM_RD,
        ST_RM_POS,
        ST_RM_SCAN,
        ST_CALC,
        ST_PER_WAIT,
        ST_COUNT,
        ST_SHIFT,
        ST_WRITE,
        ST_F_CHK,
        ST_F_HEAD,
        ST_F_RD,
        ST_F_EVAL,
        ST_F_END
    } t_state;

    typedef enum logic [1:0] {
        FL_SET,
        FL_CANCEL,
        FL_FIRE
    } t_flow;

    typedef enum logic [2:0] {
        SCAN_NONE,
        SCAN_REMOVE,
        SCAN_COUNT,
        SCAN_SHIFT,
        SCAN_HEAD
    } t_scan;

    typedef struct packed {
        logic  load_req;
        logic  rd_slot;
        logic  ld_pos;
        logic  ld_ent;
        logic  scan_start;
        logic  clr_p;
        t_scan scan_mode;
        logic  clr_armed;
        logic  set_armed;
        logic  per_start;
        logic  wr_slot;
        logic  fire_init;
        logic  take_head;
        logic  capture;
        logic  push;
        logic  push_last;
    } t_cmd;

    typedef struct packed {
        logic in_set;
        logic in_cancel;
        logic in_fire;
        logic id_ok;
        logic id_armed;
        logic req_periodic;
        logic ent_periodic;
        logic scan_done;
        logic head_found;
        logic head_due;
        logic per_busy;
        logic nout_full;
        logic out_free;
        logic pend_vld;
    } t_sts;

    function automatic logic [TW-1:0] sat63(input logic [TW:0] v);
        return v[TW] ? {TW{1'b1}} : v[TW-1:0];
    endfunction

endpackage

/* rtl/satq_div.sv */
// bit-serial remainder unit, 63-bit dividend by 32-bit divisor
module satq_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [satq_pkg::TW-1:0]  i_dividend,
    input  logic [satq_pkg::PW-1:0]  i_divisor,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [satq_pkg::PW-1:0]  o_rem
);

    localparam int TW = satq_pkg::TW;
    localparam int PW = satq_pkg::PW;
    localparam int CNW = $clog2(TW);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [TW-1:0]  r_num;
    logic [PW-1:0]  r_div;
    logic [PW-1:0]  r_rem;
    logic [PW:0]    trial;

    assign trial = {r_rem, r_num[TW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_div}) begin
                    r_rem <= PW'(trial - {1'b0, r_div});
                end else begin
                    r_rem <= trial[PW-1:0];
                end
                r_num <= {r_num[TW-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(TW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* rtl/satq_datapath.sv */
// slot memories, scan engine, pending result and output register
module satq_datapath #(
    parameter int NUM_ALARMS = satq_pkg::NUM_ALARMS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  satq_pkg::t_cmd                  i_cmd,
    output satq_pkg::t_sts                  o_sts,
    input  logic [satq_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [2:0]                      i_s_tuser,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [satq_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast
);

    localparam int TW = satq_pkg::TW;
    localparam int PW = satq_pkg::PW;
    localparam int HW = satq_pkg::HW;
    localparam int SW = $clog2(NUM_ALARMS);
    localparam int CW = SW + 1;
    localparam int MAX_RES = (NUM_ALARMS < satq_pkg::MAX_RESULTS) ?
                             NUM_ALARMS : satq_pkg::MAX_RESULTS;
    localparam int NW = $clog2(MAX_RES + 1);

    // input word fields
    logic [2:0]    in_type;
    logic [3:0]    in_id;
    logic [TW-1:0] in_tv;
    logic [PW-1:0] in_pv;
    logic [HW-1:0] in_hc;
    logic [TW-1:0] in_now;
    logic [SW-1:0] in_slot;

    assign in_type = i_s_tuser;
    assign in_id   = i_s_tdata[3:0];
    assign in_tv   = i_s_tdata[66:4];
    assign in_pv   = i_s_tdata[98:67];
    assign in_hc   = i_s_tdata[106:99];
    assign in_now  = i_s_tdata[169:107];
    assign in_slot = SW'(in_id);

    // slot memories
    logic [TW-1:0] mem_fire  [NUM_ALARMS];
    logic [PW-1:0] mem_per   [NUM_ALARMS];
    logic [TW-1:0] mem_start [NUM_ALARMS];
    logic [HW-1:0] mem_hnd   [NUM_ALARMS];
    logic [SW-1:0] mem_qpos  [NUM_ALARMS];

    logic [NUM_ALARMS-1:0] r_armed;
    logic [NUM_ALARMS-1:0] r_done;

    logic [2:0]    r_type;
    logic [TW-1:0] r_now;
    logic [SW-1:0] r_slot;
    logic [TW-1:0] r_f;
    logic [SW-1:0] r_p;
    logic [PW-1:0] r_ent_period;
    logic [TW-1:0] r_ent_start;
    logic [HW-1:0] r_ent_handler;

    logic [CW-1:0] r_cnt;
    logic          r_rd_vld;
    logic [SW-1:0] r_rd_idx;
    logic [TW-1:0] r_rd_fire;
    logic [PW-1:0] r_rd_per;
    logic [TW-1:0] r_rd_start;
    logic [HW-1:0] r_rd_hnd;
    logic [SW-1:0] r_rd_qpos;

    logic          r_hfound;
    logic [SW-1:0] r_head;
    logic [NW-1:0] r_nout;

    logic          r_pend_vld;
    logic [3:0]    r_pend_id;
    logic [HW-1:0] r_pend_hnd;
    logic [TW-1:0] r_pend_due;

    logic          r_out_vld;
    logic          r_out_last;
    logic [3:0]    r_out_id;
    logic [HW-1:0] r_out_hnd;
    logic [TW-1:0] r_out_due;

    logic          div_busy;
    logic          div_done;
    logic [PW-1:0] div_rem;
    logic          div_start;

    logic          scanning;
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          hit;
    logic          qp_we;
    logic [SW-1:0] qp_wa;
    logic [SW-1:0] qp_wd;
    logic          out_free;

    assign scanning = (i_cmd.scan_mode != satq_pkg::SCAN_NONE) &&
                      (r_cnt < CW'(NUM_ALARMS));
    assign rd_en    = i_cmd.rd_slot || scanning;
    assign rd_addr  = i_cmd.rd_slot ? r_slot : r_cnt[SW-1:0];
    // armed entry other than the slot being moved
    assign hit      = r_rd_vld && r_armed[r_rd_idx] && (r_rd_idx != r_slot);
    assign out_free = !r_out_vld || i_m_tready;

    assign div_start = i_cmd.per_start && (r_ent_period != '0) &&
                       !(r_ent_start > r_now);

    always_comb begin
        qp_we = 1'b0;
        qp_wa = r_rd_idx;
        qp_wd = r_rd_qpos;
        if (i_cmd.wr_slot) begin
            qp_we = 1'b1;
            qp_wa = r_slot;
            qp_wd = r_p;
        end else if (i_cmd.scan_mode == satq_pkg::SCAN_REMOVE) begin
            qp_we = hit && (r_rd_qpos > r_p);
            qp_wd = r_rd_qpos - 1'b1;
        end else if (i_cmd.scan_mode == satq_pkg::SCAN_SHIFT) begin
            qp_we = hit && (r_rd_qpos >= r_p);
            qp_wd = r_rd_qpos + 1'b1;
        end
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_slot) begin
            mem_fire[r_slot]  <= r_f;
            mem_per[r_slot]   <= r_ent_period;
            mem_start[r_slot] <= r_ent_start;
            mem_hnd[r_slot]   <= r_ent_handler;
        end
        if (qp_we) begin
            mem_qpos[qp_wa] <= qp_wd;
        end
        if (rd_en) begin
            r_rd_fire  <= mem_fire[rd_addr];
            r_rd_per   <= mem_per[rd_addr];
            r_rd_start <= mem_start[rd_addr];
            r_rd_hnd   <= mem_hnd[rd_addr];
            r_rd_qpos  <= mem_qpos[rd_addr];
        end
        r_rd_idx <= rd_addr;
    end

    satq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_now - r_ent_start),
        .i_divisor  (r_ent_period),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= '0;
            r_done     <= '0;
            r_cnt      <= CW'(NUM_ALARMS);
            r_rd_vld   <= 1'b0;
            r_hfound   <= 1'b0;
            r_nout     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld <= scanning;
            if (i_cmd.scan_start) begin
                r_cnt    <= '0;
                r_hfound <= 1'b0;
            end else if (scanning) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if ((i_cmd.scan_mode == satq_pkg::SCAN_HEAD) && r_rd_vld &&
                r_armed[r_rd_idx] && (r_rd_qpos == '0)) begin
                r_hfound <= 1'b1;
            end
            if (i_cmd.clr_armed) begin
                r_armed[r_slot] <= 1'b0;
            end
            if (i_cmd.set_armed) begin
                r_armed[r_slot] <= 1'b1;
            end
            if (i_cmd.fire_init) begin
                r_done     <= '0;
                r_nout     <= '0;
                r_pend_vld <= 1'b0;
            end
            if (i_cmd.push) begin
                r_pend_vld <= 1'b0;
            end
            if (i_cmd.capture) begin
                r_done[r_slot] <= 1'b1;
                r_nout         <= r_nout + 1'b1;
                r_pend_vld     <= 1'b1;
            end
            if (i_cmd.push) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type        <= in_type;
            r_now         <= in_now;
            r_slot        <= in_slot;
            r_ent_handler <= in_hc;
            r_ent_start   <= in_tv;
            r_ent_period  <= (in_type == satq_pkg::REQ_PERIODIC) ? in_pv : '0;
            case (in_type)
                satq_pkg::REQ_REL: r_f <= satq_pkg::sat63({1'b0, in_now} + {1'b0, in_tv});
                satq_pkg::REQ_ABS: r_f <= in_tv;
                default:           r_f <= in_tv;
            endcase
        end
        if (i_cmd.take_head) begin
            r_slot <= r_head;
        end
        if (i_cmd.ld_ent) begin
            r_ent_period  <= r_rd_per;
            r_ent_start   <= r_rd_start;
            r_ent_handler <= r_rd_hnd;
        end
        // next periodic fire time
        if (i_cmd.per_start) begin
            if (r_ent_period == '0) begin
                r_f <= '0;
            end else if (r_ent_start > r_now) begin
                r_f <= r_ent_start;
            end
        end
        if (div_done) begin
            r_f <= satq_pkg::sat63({1'b0, r_now} - {32'd0, div_rem} +
                                   {32'd0, r_ent_period});
        end
        if (i_cmd.clr_p) begin
            r_p <= '0;
        end else if (i_cmd.ld_pos) begin
            r_p <= r_rd_qpos;
        end else if ((i_cmd.scan_mode == satq_pkg::SCAN_COUNT) && hit &&
                     (r_rd_fire <= r_f)) begin
            r_p <= r_p + 1'b1;
        end
        if ((i_cmd.scan_mode == satq_pkg::SCAN_HEAD) && r_rd_vld &&
            r_armed[r_rd_idx] && (r_rd_qpos == '0)) begin
            r_head <= r_rd_idx;
        end
        if (i_cmd.capture) begin
            r_pend_id  <= 4'(r_slot);
            r_pend_hnd <= r_rd_hnd;
            r_pend_due <= r_rd_fire;
        end
        if (i_cmd.push) begin
            r_out_id   <= r_pend_id;
            r_out_hnd  <= r_pend_hnd;
            r_out_due  <= r_pend_due;
            r_out_last <= i_cmd.push_last;
        end
    end

    always_comb begin
        o_sts.in_set       = (in_type <= satq_pkg::REQ_PERIODIC);
        o_sts.in_cancel    = (in_type == satq_pkg::REQ_CANCEL);
        o_sts.in_fire      = (in_type == satq_pkg::REQ_FIRE);
        o_sts.id_ok        = (7'(in_id) < 7'(NUM_ALARMS));
        o_sts.id_armed     = (7'(in_id) < 7'(NUM_ALARMS)) && r_armed[in_slot];
        o_sts.req_periodic = (r_type == satq_pkg::REQ_PERIODIC);
        o_sts.ent_periodic = (r_ent_period != '0);
        o_sts.scan_done    = (r_cnt == CW'(NUM_ALARMS)) && !r_rd_vld;
        o_sts.head_found   = r_hfound;
        o_sts.head_due     = (r_rd_fire <= r_now) && !r_done[r_slot];
        o_sts.per_busy     = div_busy || div_done;
        o_sts.nout_full    = (r_nout == NW'(MAX_RES));
        o_sts.out_free     = out_free;
        o_sts.pend_vld     = r_pend_vld;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0, r_out_due, r_out_hnd, r_out_id};
    assign o_m_tlast  = r_out_last;

endmodule

/* rtl/satq_ctrl.sv */
// request sequencer of the alarm queue
module satq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  satq_pkg::t_sts i_sts,
    output satq_pkg::t_cmd o_cmd
);

    satq_pkg::t_state r_state, n_state;
    satq_pkg::t_flow  r_flow, n_flow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= satq_pkg::ST_IDLE;
            r_flow  <= satq_pkg::FL_SET;
        end else begin
            r_state <= n_state;
            r_flow  <= n_flow;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_flow     = r_flow;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            satq_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_sts.in_set && i_sts.id_ok) begin
                        o_cmd.load_req = 1'b1;
                        n_flow  = satq_pkg::FL_SET;
                        n_state = i_sts.id_armed ? satq_pkg::ST_RM_RD : satq_pkg::ST_CALC;
                    end else if (i_sts.in_cancel && i_sts.id_armed) begin
                        o_cmd.load_req = 1'b1;
                        n_flow  = satq_pkg::FL_CANCEL;
                        n_state = satq_pkg::ST_RM_RD;
                    end else if (i_sts.in_fire) begin
                        o_cmd.load_req  = 1'b1;
                        o_cmd.fire_init = 1'b1;
                        n_flow  = satq_pkg::FL_FIRE;
                        n_state = satq_pkg::ST_F_CHK;
                    end
                end
            end
            satq_pkg::ST_RM_RD: begin
                o_cmd.rd_slot = 1'b1;
                n_state = satq_pkg::ST_RM_POS;
            end
            satq_pkg::ST_RM_POS: begin
                o_cmd.ld_pos     = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state = satq_pkg::ST_RM_SCAN;
            end
            satq_pkg::ST_RM_SCAN: begin
                o_cmd.scan_mode = satq_pkg::SCAN_REMOVE;
                if (i_sts.scan_done) begin
                    o_cmd.clr_armed = 1'b1;
                    case (r_flow)
                        satq_pkg::FL_SET:    n_state = satq_pkg::ST_CALC;
                        satq_pkg::FL_CANCEL: n_state = satq_pkg::ST_IDLE;
                        default: begin
                            n_state = i_sts.ent_periodic ? satq_pkg::ST_CALC
                                                         : satq_pkg::ST_F_CHK;
                        end
                    endcase
                end
            end
            satq_pkg::ST_CALC: begin
                if ((r_flow == satq_pkg::FL_FIRE) || i_sts.req_periodic) begin
                    o_cmd.per_start = 1'b1;
                    n_state = satq_pkg::ST_PER_WAIT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.clr_p      = 1'b1;
                    n_state = satq_pkg::ST_COUNT;
                end
            end
            satq_pkg::ST_PER_WAIT: begin
                if (!i_sts.per_busy) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.clr_p      = 1'b1;
                    n_state = satq_pkg::ST_COUNT;
                end
            end
            satq_pkg::ST_COUNT: begin
                o_cmd.scan_mode = satq_pkg::SCAN_COUNT;
                if (i_sts.scan_done) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = satq_pkg::ST_SHIFT;
                end
            end
            satq_pkg::ST_SHIFT: begin
                o_cmd.scan_mode = satq_pkg::SCAN_SHIFT;
                if (i_sts.scan_done) begin
                    n_state = satq_pkg::ST_WRITE;
                end
            end
            satq_pkg::ST_WRITE: begin
                o_cmd.wr_slot   = 1'b1;
                o_cmd.set_armed = 1'b1;
                n_state = (r_flow == satq_pkg::FL_FIRE) ? satq_pkg::ST_F_CHK
                                                        : satq_pkg::ST_IDLE;
            end
            satq_pkg::ST_F_CHK: begin
                if (i_sts.nout_full) begin
                    n_state = satq_pkg::ST_F_END;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state = satq_pkg::ST_F_HEAD;
                end
            end
            satq_pkg::ST_F_HEAD: begin
                o_cmd.scan_mode = satq_pkg::SCAN_HEAD;
                if (i_sts.scan_done) begin
                    if (i_sts.head_found) begin
                        o_cmd.take_head = 1'b1;
                        n_state = satq_pkg::ST_F_RD;
                    end else begin
                        n_state = satq_pkg::ST_F_END;
                    end
                end
            end
            satq_pkg::ST_F_RD: begin
                o_cmd.rd_slot = 1'b1;
                n_state = satq_pkg::ST_F_EVAL;
            end
            satq_pkg::ST_F_EVAL: begin
                if (!i_sts.head_due) begin
                    n_state = satq_pkg::ST_F_END;
                end else if (!i_sts.pend_vld || i_sts.out_free) begin
                    // earlier result goes out, not the last one
                    o_cmd.push       = i_sts.pend_vld;
                    o_cmd.capture    = 1'b1;
                    o_cmd.ld_pos     = 1'b1;
                    o_cmd.ld_ent     = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state = satq_pkg::ST_RM_SCAN;
                end
            end
            satq_pkg::ST_F_END: begin
                if (!i_sts.pend_vld) begin
                    n_state = satq_pkg::ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    n_state = satq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = satq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/sorted_alarm_timer_queue.sv */
// top level of the sorted alarm timer queue
// one request word at a time; ready only while idle, even while a result waits in the out register
// set: an armed slot is removed first; a periodic set can run the 63-step remainder unit
// fire check: each fired alarm is removed and a periodic one rearmed; output stalls hold the flow
// reset clears the armed flags and control state, not the slot memories
module sorted_alarm_timer_queue #(
    parameter int NUM_ALARMS = satq_pkg::NUM_ALARMS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // alarm_id, time_value, period_value, handler_code, now (zero padded)
    input  logic [satq_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // req_type
    input  logic [2:0]                      i_s_tuser,
    // fired alarm channel
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // fired_id, fired_handler, due_time (zero padded)
    output logic [satq_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // last_fired
    output logic                            o_m_tlast
);

    satq_pkg::t_cmd cmd;
    satq_pkg::t_sts sts;

    // sequencer: arm, cancel and fire flows built from slot scans
    satq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // slot storage, rank bookkeeping, remainder unit and output word
    satq_datapath #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

/* tb/tb_sorted_alarm_timer_queue.sv */
// testbench for the sorted alarm timer queue: random and directed requests, checked fired words
`timescale 1ns / 1ps

module tb_sorted_alarm_timer_queue;

    localparam int  TW          = satq_pkg::TW;
    localparam int  PW          = satq_pkg::PW;
    localparam int  HW          = satq_pkg::HW;
    localparam int  IN_DATA_W   = satq_pkg::IN_DATA_W;
    localparam int  OUT_DATA_W  = satq_pkg::OUT_DATA_W;
    localparam int  MAX_RESULTS = satq_pkg::MAX_RESULTS;
    localparam logic [2:0] REQ_REL      = satq_pkg::REQ_REL;
    localparam logic [2:0] REQ_ABS      = satq_pkg::REQ_ABS;
    localparam logic [2:0] REQ_PERIODIC = satq_pkg::REQ_PERIODIC;
    localparam logic [2:0] REQ_CANCEL   = satq_pkg::REQ_CANCEL;
    localparam logic [2:0] REQ_FIRE     = satq_pkg::REQ_FIRE;

    localparam int  NSLOT     = 16;
    localparam int  CYCLE_CAP = 2000000;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    typedef struct {
        logic [2:0]    req;
        logic [3:0]    id;
        logic [TW-1:0] tval;
        logic [PW-1:0] per;
        logic [HW-1:0] hc;
        logic [TW-1:0] now;
    } t_req;

    typedef struct {
        logic [3:0]    id;
        logic [HW-1:0] hc;
        logic [TW-1:0] due;
        logic          last;
    } t_fired;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tready = 1'b0;
    logic s_tready, m_tvalid, m_tlast;
    logic [OUT_DATA_W-1:0] m_tdata;

    t_req   pending_reqs[$];
    t_fired fired_due[$];
    int     errors = 0;
    int     fired_seen = 0;
    int     cycles = 0;
    int     tx_gap = 0;
    int     rx_wait = 0;
    int     rx_hold = 0;
    bit     hold_done = 0;
    bit     no_idle = 0;

    // shadow of the alarm slots
    bit            sh_armed[NSLOT];
    logic [TW-1:0] sh_fire[NSLOT];
    logic [PW-1:0] sh_per[NSLOT];
    logic [TW-1:0] sh_start[NSLOT];
    logic [HW-1:0] sh_tag[NSLOT];
    int            sh_pos[NSLOT];

    sorted_alarm_timer_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic void unlink_slot(int s);
        for (int i = 0; i < NSLOT; i++)
            if (i != s && sh_armed[i] && sh_pos[i] > sh_pos[s]) sh_pos[i]--;
        sh_armed[s] = 0;
    endfunction

    // ties go behind every slot with an equal fire time
    function automatic void link_slot(int s, logic [TW-1:0] f);
        int p;
        p = 0;
        for (int i = 0; i < NSLOT; i++)
            if (i != s && sh_armed[i] && sh_fire[i] <= f) p++;
        for (int i = 0; i < NSLOT; i++)
            if (i != s && sh_armed[i] && sh_pos[i] >= p) sh_pos[i]++;
        sh_fire[s] = f;
        sh_pos[s] = p;
        sh_armed[s] = 1;
    endfunction

    function automatic logic [TW-1:0] next_period_time(int s, logic [TW-1:0] now);
        logic [63:0] f;
        if (sh_per[s] == 0) return '0;
        if (sh_start[s] > now) return sh_start[s];
        f = {1'b0, now} - (({1'b0, now} - {1'b0, sh_start[s]}) % {32'd0, sh_per[s]})
            + {32'd0, sh_per[s]};
        return f[63] ? TMAX : f[TW-1:0];
    endfunction

    function automatic void predict_alarms(t_req r);
        int s;
        logic [63:0] sum;
        bit fired[NSLOT];
        int n;
        int h;
        t_fired w;
        s = r.id;
        case (r.req)
            REQ_CANCEL: if (sh_armed[s]) unlink_slot(s);
            REQ_REL, REQ_ABS, REQ_PERIODIC: begin
                if (sh_armed[s]) unlink_slot(s);
                sh_tag[s] = r.hc;
                if (r.req == REQ_REL) begin
                    sum = {1'b0, r.now} + {1'b0, r.tval};
                    sh_per[s] = '0;
                    link_slot(s, sum[63] ? TMAX : sum[TW-1:0]);
                end else if (r.req == REQ_ABS) begin
                    sh_per[s] = '0;
                    link_slot(s, r.tval);
                end else begin
                    sh_per[s] = r.per;
                    sh_start[s] = r.tval;
                    link_slot(s, next_period_time(s, r.now));
                end
            end
            REQ_FIRE: begin
                n = 0;
                fired = '{default: 0};
                while (n < MAX_RESULTS && n < NSLOT) begin
                    h = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (sh_armed[i] && sh_pos[i] == 0) h = i;
                    if (h < 0 || sh_fire[h] > r.now || fired[h]) break;
                    w.id = 4'(h);
                    w.hc = sh_tag[h];
                    w.due = sh_fire[h];
                    w.last = 0;
                    unlink_slot(h);
                    if (sh_per[h] > 0) link_slot(h, next_period_time(h, r.now));
                    fired[h] = 1;
                    fired_due.push_back(w);
                    n++;
                end
                if (n > 0) fired_due[fired_due.size() - 1].last = 1;
            end
            default: ;
        endcase
    endfunction

    // sender: words come from pending_reqs, with a random idle gap between them unless no_idle is set
    always @(posedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                r.req  = s_tuser;
                r.id   = s_tdata[3:0];
                r.tval = s_tdata[66:4];
                r.per  = s_tdata[98:67];
                r.hc   = s_tdata[106:99];
                r.now  = s_tdata[169:107];
                predict_alarms(r);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    // fields from bit 0: alarm_id, time_value, period_value, handler_code, now
                    s_tdata <= {6'd0, r.now, r.hc, r.per, r.tval, r.id};
                    s_tuser <= r.req;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 15) == 0) no_idle <= ~no_idle;
                    tx_gap <= no_idle ? 0 : $urandom_range(0, 3);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each fired word against the oldest prediction
    always @(posedge i_clk) begin
        t_fired got, want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.id   = m_tdata[3:0];
                got.hc   = m_tdata[11:4];
                got.due  = m_tdata[74:12];
                got.last = m_tlast;
                fired_seen++;
                if (fired_due.size() == 0) begin
                    $display("%0t: unexpected fired word id=%0d hc=%0d due=%0d last=%0b",
                             $time, got.id, got.hc, got.due, got.last);
                    errors++;
                end else begin
                    want = fired_due.pop_front();
                    if (got.id !== want.id) begin
                        $display("%0t: fired_id exp %0d got %0d", $time, want.id, got.id);
                        errors++;
                    end
                    if (got.hc !== want.hc) begin
                        $display("%0t: fired_handler exp %0d got %0d", $time, want.hc, got.hc);
                        errors++;
                    end
                    if (got.due !== want.due) begin
                        $display("%0t: due_time exp %0d got %0d", $time, want.due, got.due);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_fired exp %0b got %0b", $time, want.last, got.last);
                        errors++;
                    end
                end
            end
            if (!hold_done && fired_seen == 20) begin
                // long back-pressure so the output register fills and the input stalls
                hold_done <= 1;
                rx_hold <= 3000;
                m_tready <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                rx_wait <= no_idle ? 0 : $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("** sorted_alarm_timer_queue: FAILED **");
            $finish;
        end
    end

    function automatic logic [TW-1:0] rand_time();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req mk(logic [2:0] q, logic [3:0] id, logic [TW-1:0] tv,
                                logic [PW-1:0] pv, logic [HW-1:0] hc, logic [TW-1:0] now);
        t_req r;
        r.req = q; r.id = id; r.tval = tv; r.per = pv; r.hc = hc; r.now = now;
        return r;
    endfunction

    initial begin
        logic [TW-1:0] tnow;
        int kind;
        sh_armed = '{default: 0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: saturation, extremes, ties, periodic corners, cancel, junk codes
        pending_reqs.push_back(mk(REQ_REL, 4'd0, TMAX, 32'd0, 8'hFF, 63'd5));
        pending_reqs.push_back(mk(REQ_ABS, 4'd1, 63'd0, 32'hFFFF_FFFF, 8'h00, TMAX));
        pending_reqs.push_back(mk(REQ_ABS, 4'd2, 63'd100, 32'd0, 8'h12, 63'd0));
        pending_reqs.push_back(mk(REQ_ABS, 4'd3, 63'd100, 32'd0, 8'h34, 63'd0));
        pending_reqs.push_back(mk(REQ_PERIODIC, 4'd4, 63'd200, 32'd7, 8'h56, 63'd10));
        pending_reqs.push_back(mk(REQ_PERIODIC, 4'd5, 63'd50, 32'd10, 8'h78, 63'd50));
        pending_reqs.push_back(mk(REQ_PERIODIC, 4'd6, 63'd3, 32'd0, 8'h9A, 63'd40));
        pending_reqs.push_back(mk(REQ_PERIODIC, 4'd7, 63'd1, 32'hFFFF_FFFF, 8'hBC, 63'd90));
        pending_reqs.push_back(mk(REQ_CANCEL, 4'd15, 63'd0, 32'd0, 8'd0, 63'd0));
        pending_reqs.push_back(mk(REQ_CANCEL, 4'd3, 63'd0, 32'd0, 8'd0, 63'd0));
        pending_reqs.push_back(mk(REQ_ABS, 4'd2, 63'd60, 32'd0, 8'h21, 63'd0));
        pending_reqs.push_back(mk(3'd5, 4'd8, TMAX, 32'hFFFF_FFFF, 8'hFF, TMAX));
        pending_reqs.push_back(mk(3'd6, 4'd9, 63'd1, 32'd1, 8'd1, 63'd1));
        pending_reqs.push_back(mk(3'd7, 4'd10, 63'd2, 32'd2, 8'd2, 63'd2));
        pending_reqs.push_back(mk(REQ_FIRE, 4'd0, 63'd0, 32'd0, 8'd0, 63'd150));
        pending_reqs.push_back(mk(REQ_FIRE, 4'd0, 63'd0, 32'd0, 8'd0, 63'd300));
        // periodic whose next time saturates, then two checks at the top of time
        pending_reqs.push_back(mk(REQ_PERIODIC, 4'd11, 63'd0, 32'd3, 8'hC3,
                                  TMAX - 63'd1));
        pending_reqs.push_back(mk(REQ_FIRE, 4'd0, 63'd0, 32'd0, 8'd0, TMAX));
        pending_reqs.push_back(mk(REQ_FIRE, 4'd0, 63'd0, 32'd0, 8'd0, TMAX));
        // all slots due at once: full-size check
        for (int i = 0; i < NSLOT; i++)
            pending_reqs.push_back(mk(REQ_ABS, i[3:0], 63'd0, 32'd0, i[7:0] ^ 8'hA5, 63'd0));
        pending_reqs.push_back(mk(REQ_FIRE, 4'd0, 63'd0, 32'd0, 8'd0, 63'd0));

        // random: a slowly advancing clock, mostly well-formed, some wild values
        tnow = 63'd1000;
        for (int n = 0; n < 200; n++) begin
            tnow = tnow + $urandom_range(0, 40);
            kind = $urandom_range(0, 99);
            if (kind < 30)
                pending_reqs.push_back(mk(REQ_REL, $urandom, $urandom_range(0, 120), $urandom,
                                          $urandom, tnow));
            else if (kind < 42)
                pending_reqs.push_back(mk(REQ_ABS, $urandom, tnow + $urandom_range(0, 150) - 30,
                                          $urandom, $urandom, tnow));
            else if (kind < 56)
                pending_reqs.push_back(mk(REQ_PERIODIC, $urandom,
                                          tnow + $urandom_range(0, 100) - 60,
                                          $urandom_range(0, 50), $urandom, tnow));
            else if (kind < 66)
                pending_reqs.push_back(mk(REQ_CANCEL, $urandom, rand_time(), $urandom,
                                          $urandom, tnow));
            else if (kind < 90)
                pending_reqs.push_back(mk(REQ_FIRE, $urandom, rand_time(), $urandom,
                                          $urandom, tnow));
            else if (kind < 94)
                pending_reqs.push_back(mk($urandom_range(0, 7), $urandom, rand_time(),
                                          $urandom, $urandom, rand_time()));
            else
                pending_reqs.push_back(mk($urandom_range(0, 2), $urandom, rand_time(),
                                          $urandom, $urandom, tnow));
        end
        pending_reqs.push_back(mk(REQ_FIRE, 4'd0, 63'd0, 32'd0, 8'd0, TMAX));

        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (fired_due.size() == 0);
        repeat (500) @(posedge i_clk);
        if (errors == 0 && fired_due.size() == 0)
            $display("** sorted_alarm_timer_queue: PASSED **");
        else
            $display("** sorted_alarm_timer_queue: FAILED **");
        $finish;
    end

endmodule
